// File: sv/lucm_pkg.sv
package lucm_pkg;

    // field widths
    localparam int PIX_W  = 12;
    localparam int FIX_W  = 20;
    localparam int COEF_W = 24;
    localparam int NORM_W = 24;
    localparam int FRAC_W = 20;
    localparam int XD_W   = 42;
    localparam int SRC_W  = 21;
    localparam int CFG_W  = 24;

    // image size defaults
    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    // register reset values
    localparam logic [FIX_W-1:0] RST_FOCAL_X  = FIX_W'(128000);
    localparam logic [FIX_W-1:0] RST_FOCAL_Y  = FIX_W'(128000);
    localparam logic [FIX_W-1:0] RST_CENTER_X = FIX_W'(81920);
    localparam logic [FIX_W-1:0] RST_CENTER_Y = FIX_W'(61440);

    // pipeline depths
    localparam int DIV_LAT  = NORM_W + 2;
    localparam int POLY_LAT = 8;
    localparam int OUT_LAT  = 4;
    localparam int PIPE_LAT = DIV_LAT + POLY_LAT + OUT_LAT;

    // register indexes
    typedef enum logic [2:0] {
        CFG_FOCAL_X,
        CFG_FOCAL_Y,
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_RADIAL_K1,
        CFG_RADIAL_K2,
        CFG_TAN_P1,
        CFG_TAN_P2
    } t_cfg_idx;

    // distortion coefficients, Q3.20
    typedef struct packed {
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] p1;
        logic signed [COEF_W-1:0] p2;
    } t_coef;

endpackage

// File: sv/lucm_div.sv
module lucm_div import lucm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [PIX_W-1:0]         i_pix,
    input  logic [FIX_W-1:0]         i_center,
    input  logic [FIX_W-1:0]         i_focal,
    output logic                     o_valid,
    output logic signed [NORM_W-1:0] o_norm
);

    localparam int NUM_W = FIX_W + FRAC_W + 1;
    localparam int HI_W  = NUM_W - NORM_W;
    localparam logic [NORM_W-1:0] POS_MAX = {1'b0, {(NORM_W-1){1'b1}}};
    localparam logic [NORM_W-1:0] NEG_MAX = {1'b1, {(NORM_W-1){1'b0}}};

    logic signed [FIX_W+1:0] offs;
    logic signed [FIX_W+1:0] offs_neg;
    logic [FIX_W-1:0]        mag;
    logic [NUM_W-1:0]        numer;
    logic [FIX_W-1:0]        numer_hi;

    logic [FIX_W-1:0]  r_rem [0:NORM_W];
    logic [NORM_W-1:0] r_num [0:NORM_W];
    logic [NORM_W-1:0] r_q   [0:NORM_W];
    logic              r_neg [0:NORM_W];
    logic              r_ovf [0:NORM_W];
    logic              r_vld [0:NORM_W];
    logic              r_out_vld;

    // offset from the principal point and rounded numerator
    assign offs     = $signed({2'b00, i_pix, 8'h00}) - $signed({2'b00, i_center});
    assign offs_neg = -offs;
    assign mag      = offs[FIX_W+1] ? offs_neg[FIX_W-1:0] : offs[FIX_W-1:0];
    assign numer    = {1'b0, mag, {FRAC_W{1'b0}}}
                    + {{(FRAC_W+2){1'b0}}, i_focal[FIX_W-1:1]};
    assign numer_hi = {{(FIX_W-HI_W){1'b0}}, numer[NUM_W-1:NORM_W]};

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0] <= numer_hi;
        r_num[0] <= numer[NORM_W-1:0];
        r_q[0]   <= '0;
        r_neg[0] <= offs[FIX_W+1];
        r_ovf[0] <= numer_hi >= i_focal;
    end

    // one restoring quotient bit per stage
    for (genvar s = 0; s < NORM_W; s++) begin : g_step
        logic [FIX_W:0] trial;
        logic           fits;

        assign trial = {r_rem[s], r_num[s][NORM_W-1]};
        assign fits  = trial >= {1'b0, i_focal};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1] <= fits ? FIX_W'(trial - {1'b0, i_focal}) : trial[FIX_W-1:0];
            r_num[s+1] <= {r_num[s][NORM_W-2:0], 1'b0};
            r_q[s+1]   <= {r_q[s][NORM_W-2:0], fits};
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
        end
    end

    // sign and saturation to Q3.20
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NORM_W];
        end
        if (r_neg[NORM_W]) begin
            if (r_ovf[NORM_W] || r_q[NORM_W] > NEG_MAX) begin
                o_norm <= $signed(NEG_MAX);
            end else begin
                o_norm <= $signed(NORM_W'(~r_q[NORM_W] + 1'b1));
            end
        end else begin
            if (r_ovf[NORM_W] || r_q[NORM_W] > POS_MAX) begin
                o_norm <= $signed(POS_MAX);
            end else begin
                o_norm <= $signed(r_q[NORM_W]);
            end
        end
    end

    assign o_valid = r_out_vld;

endmodule

// File: sv/lucm_poly.sv
module lucm_poly import lucm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [NORM_W-1:0] i_x,
    input  logic signed [NORM_W-1:0] i_y,
    input  t_coef                    i_coef,
    output logic                     o_valid,
    output logic signed [XD_W-1:0]   o_xd,
    output logic signed [XD_W-1:0]   o_yd
);

    localparam logic signed [59:0] ONE_Q40 = 60'sd1 <<< 40;

    logic [POLY_LAT-1:0] r_vld;

    logic signed [23:0] r1_x, r1_y;
    logic signed [47:0] r1_xx, r1_yy, r1_xy;

    logic signed [48:0] sum_r2, sum_xx, sum_yy, sum_xy;
    logic signed [23:0] r2_x, r2_y;
    logic signed [28:0] r2_r2, r2_xx20, r2_yy20, r2_xy20;

    logic signed [23:0] r3_x, r3_y;
    logic signed [29:0] r3_sx, r3_sy;
    logic signed [57:0] r3_r2sq;
    logic signed [52:0] r3_k1r2, r3_pxy1, r3_pxy2;

    logic signed [57:0] sum_r4;
    logic signed [23:0] r4_x, r4_y;
    logic signed [35:0] r4_r4;
    logic signed [53:0] r4_tpx2, r4_tpy1;
    logic signed [52:0] r4_k1r2, r4_pxy1, r4_pxy2;

    logic signed [23:0] r5_x, r5_y;
    logic signed [42:0] r5_mlo;
    logic signed [41:0] r5_mhi;
    logic signed [55:0] r5_tx, r5_ty;
    logic signed [52:0] r5_k1r2;

    logic signed [23:0] r6_x, r6_y;
    logic signed [59:0] r6_radsum;
    logic signed [55:0] r6_tx, r6_ty;

    logic signed [44:0] r7_xl, r7_yl;
    logic signed [43:0] r7_xh, r7_yh;
    logic signed [55:0] r7_tx, r7_ty;

    logic signed [61:0] r8_sumx, r8_sumy;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[POLY_LAT-2:0], i_valid};
        end
    end

    // squares and cross product
    always_ff @(posedge i_clk) begin
        r1_x  <= i_x;
        r1_y  <= i_y;
        r1_xx <= i_x * i_x;
        r1_yy <= i_y * i_y;
        r1_xy <= i_x * i_y;
    end

    // r2 and the rounded Q.20 products
    assign sum_r2 = r1_xx + r1_yy + 49'sd524288;
    assign sum_xx = r1_xx + 49'sd524288;
    assign sum_yy = r1_yy + 49'sd524288;
    assign sum_xy = r1_xy + 49'sd524288;

    always_ff @(posedge i_clk) begin
        r2_x    <= r1_x;
        r2_y    <= r1_y;
        r2_r2   <= sum_r2[48:20];
        r2_xx20 <= sum_xx[48:20];
        r2_yy20 <= sum_yy[48:20];
        r2_xy20 <= sum_xy[48:20];
    end

    // r2 squared, k1 term, tangential cross terms
    always_ff @(posedge i_clk) begin
        r3_x    <= r2_x;
        r3_y    <= r2_y;
        r3_sx   <= r2_r2 + (r2_xx20 <<< 1);
        r3_sy   <= r2_r2 + (r2_yy20 <<< 1);
        r3_r2sq <= r2_r2 * r2_r2;
        r3_k1r2 <= i_coef.k1 * r2_r2;
        r3_pxy1 <= i_coef.p1 * r2_xy20;
        r3_pxy2 <= i_coef.p2 * r2_xy20;
    end

    // r4 and the remaining tangential products
    assign sum_r4 = r3_r2sq + 58'sd524288;

    always_ff @(posedge i_clk) begin
        r4_x    <= r3_x;
        r4_y    <= r3_y;
        r4_r4   <= sum_r4[55:20];
        r4_tpx2 <= i_coef.p2 * r3_sx;
        r4_tpy1 <= i_coef.p1 * r3_sy;
        r4_k1r2 <= r3_k1r2;
        r4_pxy1 <= r3_pxy1;
        r4_pxy2 <= r3_pxy2;
    end

    // k2 * r4 as two partial products, tangential sums
    always_ff @(posedge i_clk) begin
        r5_x    <= r4_x;
        r5_y    <= r4_y;
        r5_mlo  <= i_coef.k2 * $signed({1'b0, r4_r4[17:0]});
        r5_mhi  <= i_coef.k2 * $signed(r4_r4[35:18]);
        r5_tx   <= (r4_pxy1 <<< 1) + r4_tpx2;
        r5_ty   <= r4_tpy1 + (r4_pxy2 <<< 1);
        r5_k1r2 <= r4_k1r2;
    end

    // radial factor with rounding, Q.40 before the shift
    always_ff @(posedge i_clk) begin
        r6_x      <= r5_x;
        r6_y      <= r5_y;
        r6_radsum <= ONE_Q40 + 60'sd524288 + r5_k1r2 + (r5_mhi <<< 18) + r5_mlo;
        r6_tx     <= r5_tx;
        r6_ty     <= r5_ty;
    end

    // coordinate times radial factor, split in halves
    always_ff @(posedge i_clk) begin
        r7_xl <= r6_x * $signed({1'b0, r6_radsum[39:20]});
        r7_xh <= r6_x * $signed(r6_radsum[59:40]);
        r7_yl <= r6_y * $signed({1'b0, r6_radsum[39:20]});
        r7_yh <= r6_y * $signed(r6_radsum[59:40]);
        r7_tx <= r6_tx;
        r7_ty <= r6_ty;
    end

    // distorted normalized coordinate with rounding
    always_ff @(posedge i_clk) begin
        r8_sumx <= (r7_xh <<< 20) + r7_xl + r7_tx + 62'sd524288;
        r8_sumy <= (r7_yh <<< 20) + r7_yl + r7_ty + 62'sd524288;
    end

    assign o_valid = r_vld[POLY_LAT-1];
    assign o_xd    = r8_sumx[61:20];
    assign o_yd    = r8_sumy[61:20];

endmodule

// File: sv/lucm_out.sv
module lucm_out import lucm_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [XD_W-1:0]  i_xd,
    input  logic signed [XD_W-1:0]  i_yd,
    input  logic [FIX_W-1:0]        i_focal_x,
    input  logic [FIX_W-1:0]        i_focal_y,
    input  logic [FIX_W-1:0]        i_center_x,
    input  logic [FIX_W-1:0]        i_center_y,
    output logic                    o_valid,
    output logic signed [SRC_W-1:0] o_src_col,
    output logic signed [SRC_W-1:0] o_src_row,
    output logic                    o_in_bounds
);

    localparam logic signed [43:0] COL_LIM = 44'(IMAGE_WIDTH * 256);
    localparam logic signed [43:0] ROW_LIM = 44'(IMAGE_HEIGHT * 256);
    localparam logic signed [43:0] SRC_MAX = 44'sd1048575;
    localparam logic signed [43:0] SRC_MIN = -44'sd1048576;

    logic [OUT_LAT-1:0] r_vld;

    logic signed [42:0] r1_pxl, r1_pyl;
    logic signed [41:0] r1_pxh, r1_pyh;
    logic signed [62:0] r2_prodx, r2_prody;
    logic signed [43:0] r3_sc, r3_sr;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[OUT_LAT-2:0], i_valid};
        end
    end

    // focal length times coordinate, split in halves
    always_ff @(posedge i_clk) begin
        r1_pxl <= $signed({1'b0, i_focal_x}) * $signed({1'b0, i_xd[20:0]});
        r1_pxh <= $signed({1'b0, i_focal_x}) * $signed(i_xd[41:21]);
        r1_pyl <= $signed({1'b0, i_focal_y}) * $signed({1'b0, i_yd[20:0]});
        r1_pyh <= $signed({1'b0, i_focal_y}) * $signed(i_yd[41:21]);
    end

    // recombine with rounding
    always_ff @(posedge i_clk) begin
        r2_prodx <= (r1_pxh <<< 21) + r1_pxl + 63'sd524288;
        r2_prody <= (r1_pyh <<< 21) + r1_pyl + 63'sd524288;
    end

    // back to pixel units
    always_ff @(posedge i_clk) begin
        r3_sc <= $signed(r2_prodx[62:20]) + $signed({1'b0, i_center_x});
        r3_sr <= $signed(r2_prody[62:20]) + $signed({1'b0, i_center_y});
    end

    // bounds check on the full value, then saturate
    always_ff @(posedge i_clk) begin
        o_in_bounds <= !r3_sc[43] && !r3_sr[43] && (r3_sc < COL_LIM) && (r3_sr < ROW_LIM);
        if (r3_sc > SRC_MAX) begin
            o_src_col <= SRC_MAX[SRC_W-1:0];
        end else if (r3_sc < SRC_MIN) begin
            o_src_col <= SRC_MIN[SRC_W-1:0];
        end else begin
            o_src_col <= r3_sc[SRC_W-1:0];
        end
        if (r3_sr > SRC_MAX) begin
            o_src_row <= SRC_MAX[SRC_W-1:0];
        end else if (r3_sr < SRC_MIN) begin
            o_src_row <= SRC_MIN[SRC_W-1:0];
        end else begin
            o_src_row <= r3_sr[SRC_W-1:0];
        end
    end

    assign o_valid = r_vld[OUT_LAT-1];

endmodule

// File: sv/lens_undistort_coord_map.sv
// throughput: one coordinate per cycle while busy is low, fully pipelined
// depth is set mainly by the restoring divider, with 24 quotient-bit stages, that normalizes by the focal length
// synchronous reset clears all pipeline valid bits and loads the register defaults
// the receiver cannot stall: each result is on the outputs for exactly one cycle
module lens_undistort_coord_map import lucm_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [PIX_W-1:0]        i_pixel_col,
    input  logic [PIX_W-1:0]        i_pixel_row,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic signed [SRC_W-1:0] o_src_col,
    output logic signed [SRC_W-1:0] o_src_row,
    output logic                    o_in_bounds
);

    logic [FIX_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    t_coef            r_coef;
    logic             r_busy;

    logic             accept;
    logic [FIX_W-1:0] focal_x_eff, focal_y_eff;

    logic                     x_vld, y_vld, poly_vld;
    logic signed [NORM_W-1:0] norm_x, norm_y;
    logic signed [XD_W-1:0]   xd, yd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= RST_FOCAL_X;
            r_focal_y  <= RST_FOCAL_Y;
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_coef     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:   r_focal_x  <= i_cfg_data[FIX_W-1:0];
                CFG_FOCAL_Y:   r_focal_y  <= i_cfg_data[FIX_W-1:0];
                CFG_CENTER_X:  r_center_x <= i_cfg_data[FIX_W-1:0];
                CFG_CENTER_Y:  r_center_y <= i_cfg_data[FIX_W-1:0];
                CFG_RADIAL_K1: r_coef.k1  <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_RADIAL_K2: r_coef.k2  <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_TAN_P1:    r_coef.p1  <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_TAN_P2:    r_coef.p2  <= $signed(i_cfg_data[COEF_W-1:0]);
                default:       r_coef     <= r_coef;
            endcase
        end
    end

    // busy is a registered flag, set during reset and cleared once reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start & ~busy;

    // a zero focal length divides as one
    assign focal_x_eff = (r_focal_x == '0) ? FIX_W'(1) : r_focal_x;
    assign focal_y_eff = (r_focal_y == '0) ? FIX_W'(1) : r_focal_y;

    lucm_div u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_pix    (i_pixel_col),
        .i_center (r_center_x),
        .i_focal  (focal_x_eff),
        .o_valid  (x_vld),
        .o_norm   (norm_x)
    );

    lucm_div u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_pix    (i_pixel_row),
        .i_center (r_center_y),
        .i_focal  (focal_y_eff),
        .o_valid  (y_vld),
        .o_norm   (norm_y)
    );

    lucm_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_vld & y_vld),
        .i_x     (norm_x),
        .i_y     (norm_y),
        .i_coef  (r_coef),
        .o_valid (poly_vld),
        .o_xd    (xd),
        .o_yd    (yd)
    );

    lucm_out #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (poly_vld),
        .i_xd        (xd),
        .i_yd        (yd),
        .i_focal_x   (r_focal_x),
        .i_focal_y   (r_focal_y),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .o_valid     (o_strobe),
        .o_src_col   (o_src_col),
        .o_src_row   (o_src_row),
        .o_in_bounds (o_in_bounds)
    );

    // every strobe traces back to an accepted start transfer at the pipe entry
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, PIPE_LAT))
        else $error("strobe without matching start transfer");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    // both divider lanes stay in step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_vld == y_vld)
        else $error("divider lanes out of step");

    // an in-bounds source never needs saturation to a negative value
    a_bounds_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_in_bounds) |-> (!o_src_col[SRC_W-1] && !o_src_row[SRC_W-1]))
        else $error("in-bounds result with negative coordinate");

endmodule

// File: test/lucm_checker.sv
// watches the coordinate map channels, predicts each distorted coordinate and compares
module lucm_checker import lucm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [PIX_W-1:0]        i_pixel_col,
    input  logic [PIX_W-1:0]        i_pixel_row,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    o_strobe,
    input  logic signed [SRC_W-1:0] o_src_col,
    input  logic signed [SRC_W-1:0] o_src_row,
    input  logic                    o_in_bounds,
    output int                      o_fail_cnt,
    output int                      o_pending,
    output int                      o_coord_cnt,
    output int                      o_inb_cnt
);

    typedef struct {
        logic signed [SRC_W-1:0] col;
        logic signed [SRC_W-1:0] row;
        logic                    inb;
    } t_src_coord;

    localparam longint NORM_MAX = 64'sd8388607;
    localparam longint NORM_MIN = -64'sd8388608;
    localparam longint SRC_MAX  = 64'sd1048575;
    localparam longint SRC_MIN  = -64'sd1048576;

    // shadow copy of the registers
    longint unsigned m_fx, m_fy, m_cx, m_cy;
    longint          m_k1, m_k2, m_p1, m_p2;

    t_src_coord expected_coords[$];

    // round half up on an arithmetic right shift
    function automatic longint rnd_shift(longint a, int s);
        return (a + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // pixel to Q.20 normalized coordinate, division rounded half away from zero
    function automatic longint norm_coord(longint unsigned pix, longint unsigned ctr,
                                          longint unsigned foc);
        longint          d;
        longint unsigned f, mag;
        longint          q;
        d   = longint'(pix * 256) - longint'(ctr);
        f   = (foc == 0) ? 1 : foc;
        mag = longint'(d < 0 ? -d : d) << 20;
        q   = longint'((mag + f / 2) / f);
        if (d < 0) q = -q;
        return sat(q, NORM_MIN, NORM_MAX);
    endfunction

    function automatic t_src_coord distort_coord(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v);
        longint x, y, xx, yy, xy, r2, r4, rad, xx20, yy20, xy20, xd, yd, sc, sr;
        t_src_coord res;
        x    = norm_coord(u, m_cx, m_fx);
        y    = norm_coord(v, m_cy, m_fy);
        xx   = x * x;
        yy   = y * y;
        xy   = x * y;
        r2   = rnd_shift(xx + yy, 20);
        r4   = rnd_shift(r2 * r2, 20);
        rad  = rnd_shift((64'sd1 <<< 40) + m_k1 * r2 + m_k2 * r4, 20);
        xx20 = rnd_shift(xx, 20);
        yy20 = rnd_shift(yy, 20);
        xy20 = rnd_shift(xy, 20);
        xd   = rnd_shift(x * rad + 2 * m_p1 * xy20 + m_p2 * (r2 + 2 * xx20), 20);
        yd   = rnd_shift(y * rad + m_p1 * (r2 + 2 * yy20) + 2 * m_p2 * xy20, 20);
        sc   = rnd_shift(longint'(m_fx) * xd, 20) + longint'(m_cx);
        sr   = rnd_shift(longint'(m_fy) * yd, 20) + longint'(m_cy);
        res.inb = sc >= 0 && sr >= 0 && sc < DEF_IMAGE_WIDTH * 256
                  && sr < DEF_IMAGE_HEIGHT * 256;
        res.col = SRC_W'(sat(sc, SRC_MIN, SRC_MAX));
        res.row = SRC_W'(sat(sr, SRC_MIN, SRC_MAX));
        return res;
    endfunction

    assign o_pending = expected_coords.size();

    // register writes, input transfers and result checks
    always @(posedge i_clk) begin
        t_src_coord exp_c;
        if (!i_rst_n) begin
            m_fx = RST_FOCAL_X;
            m_fy = RST_FOCAL_Y;
            m_cx = RST_CENTER_X;
            m_cy = RST_CENTER_Y;
            m_k1 = 0;
            m_k2 = 0;
            m_p1 = 0;
            m_p2 = 0;
            expected_coords.delete();
        end else begin
            if (o_strobe) begin
                if (expected_coords.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_cnt = o_fail_cnt + 1;
                end else begin
                    exp_c = expected_coords.pop_front();
                    o_coord_cnt <= o_coord_cnt + 1;
                    if (o_in_bounds) o_inb_cnt <= o_inb_cnt + 1;
                    if (o_src_col !== exp_c.col) begin
                        $error("src_col expected %0d actual %0d", exp_c.col, o_src_col);
                        o_fail_cnt = o_fail_cnt + 1;
                    end
                    if (o_src_row !== exp_c.row) begin
                        $error("src_row expected %0d actual %0d", exp_c.row, o_src_row);
                        o_fail_cnt = o_fail_cnt + 1;
                    end
                    if (o_in_bounds !== exp_c.inb) begin
                        $error("in_bounds expected %0d actual %0d", exp_c.inb, o_in_bounds);
                        o_fail_cnt = o_fail_cnt + 1;
                    end
                end
            end
            if (start && !busy)
                expected_coords.push_back(distort_coord(i_pixel_col, i_pixel_row));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FOCAL_X:   m_fx = i_cfg_data[FIX_W-1:0];
                    CFG_FOCAL_Y:   m_fy = i_cfg_data[FIX_W-1:0];
                    CFG_CENTER_X:  m_cx = i_cfg_data[FIX_W-1:0];
                    CFG_CENTER_Y:  m_cy = i_cfg_data[FIX_W-1:0];
                    CFG_RADIAL_K1: m_k1 = longint'($signed(i_cfg_data));
                    CFG_RADIAL_K2: m_k2 = longint'($signed(i_cfg_data));
                    CFG_TAN_P1:    m_p1 = longint'($signed(i_cfg_data));
                    CFG_TAN_P2:    m_p2 = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
        end
    end

    initial begin
        o_fail_cnt  = 0;
        o_coord_cnt = 0;
        o_inb_cnt   = 0;
    end

endmodule

// File: test/tb.sv
// stimulus for the coordinate map: register settings, directed and random pixels
module tb;
    import lucm_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [PIX_W-1:0]        i_pixel_col = '0;
    logic [PIX_W-1:0]        i_pixel_row = '0;
    logic                    i_cfg_we = 1'b0;
    logic [2:0]              i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    o_strobe;
    logic signed [SRC_W-1:0] o_src_col;
    logic signed [SRC_W-1:0] o_src_row;
    logic                    o_in_bounds;
    int                      fail_cnt, pending, coord_cnt, inb_cnt;
    int                      idle_pct;

    always #10 i_clk = ~i_clk;

    lens_undistort_coord_map uut (.*);

    lucm_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_pixel_col, .i_pixel_row,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_strobe, .o_src_col, .o_src_row,
        .o_in_bounds, .o_fail_cnt(fail_cnt), .o_pending(pending),
        .o_coord_cnt(coord_cnt), .o_inb_cnt(inb_cnt)
    );

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one pixel transfer, with a random gap before it
    task automatic send_pixel(input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] v);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_pixel_col <= u;
        i_pixel_row <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // let the pipe empty before touching the registers
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    // pixels mostly near the image, sometimes anywhere in the field range
    task automatic random_pixels(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                send_pixel(PIX_W'($urandom), PIX_W'($urandom));
            else
                send_pixel(PIX_W'($urandom_range(700)), PIX_W'($urandom_range(540)));
        end
    endtask

    function automatic logic [CFG_W-1:0] small_coef();
        return CFG_W'($signed($urandom_range(400000)) - 200000);
    endfunction

    initial begin
        idle_pct = 16;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: default registers, corners of the pixel range, image center and image edges
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(320, 240);
        send_pixel(639, 479);
        send_pixel(640, 480);
        send_pixel(12'hAAA, 12'h555);
        drain();

        // typical barrel distortion with tangential terms
        write_reg(CFG_RADIAL_K1, -24'sd300000);
        write_reg(CFG_RADIAL_K2, 24'sd80000);
        write_reg(CFG_TAN_P1, 24'sd2000);
        write_reg(CFG_TAN_P2, -24'sd1500);
        send_pixel(0, 0);
        send_pixel(639, 479);
        send_pixel(320, 240);
        send_pixel(4095, 4095);
        drain();

        // extreme coefficients, zero focal, tiny focal, center at maximum
        write_reg(CFG_FOCAL_X, 24'd0);
        write_reg(CFG_FOCAL_Y, 24'd1);
        write_reg(CFG_CENTER_X, 24'hFFFFFF);
        write_reg(CFG_CENTER_Y, 24'd0);
        write_reg(CFG_RADIAL_K1, 24'h7FFFFF);
        write_reg(CFG_RADIAL_K2, 24'h800000);
        write_reg(CFG_TAN_P1, 24'h800000);
        write_reg(CFG_TAN_P2, 24'h7FFFFF);
        write_reg(3'd7 + 3'd1, 24'd0);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 1);
        drain();

        // maximum focal lengths
        write_reg(CFG_FOCAL_X, 24'hFFFFFF);
        write_reg(CFG_FOCAL_Y, 24'h0FFFFF);
        write_reg(CFG_CENTER_X, 24'd0);
        write_reg(CFG_CENTER_Y, 24'hFFFFF);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        drain();

        // random phases with mostly realistic settings; two use full-range coefficients
        for (int ph = 0; ph < 9; ph++) begin
            idle_pct = ph < 3 ? 16 : (ph < 6 ? 62 : 0);
            write_reg(CFG_FOCAL_X, CFG_W'($urandom_range(200000, 40000)));
            write_reg(CFG_FOCAL_Y, CFG_W'($urandom_range(200000, 40000)));
            write_reg(CFG_CENTER_X, CFG_W'($urandom_range(163840)));
            write_reg(CFG_CENTER_Y, CFG_W'($urandom_range(122880)));
            write_reg(CFG_RADIAL_K1, ph == 4 ? CFG_W'($urandom) : small_coef());
            write_reg(CFG_RADIAL_K2, ph == 4 ? CFG_W'($urandom) : small_coef());
            write_reg(CFG_TAN_P1, ph == 7 ? CFG_W'($urandom) : small_coef() >>> 4);
            write_reg(CFG_TAN_P2, ph == 7 ? CFG_W'($urandom) : small_coef() >>> 4);
            random_pixels(190);
            drain();
        end

        $display("checked %0d coordinates, %0d inside the image, over 13 register settings",
                 coord_cnt, inb_cnt);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/lucm_pkg.sv
sv/lucm_div.sv
sv/lucm_poly.sv
sv/lucm_out.sv
sv/lens_undistort_coord_map.sv
test/lucm_checker.sv
test/tb.sv
